// ===== rtl/ksx_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ksx_pkg: shared types and constants of the keyed substitution scrambler
// Register indexes, reset values and the status record of the table builder.
// ----------------------------------------------------------------------------
package ksx_pkg;

    localparam int unsigned CFG_IDX_W = 8;
    localparam int unsigned KEY_W     = 32;
    localparam int unsigned BYTE_W    = 8;

    localparam logic [CFG_IDX_W-1:0] REG_TABLE_KEY = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_XOR_KEY   = 8'd1;

    localparam logic [KEY_W-1:0] TABLE_KEY_RESET = 32'h0000_0000;
    localparam logic [KEY_W-1:0] XOR_KEY_RESET   = 32'hDDCC_BBAA;

    // Status of the permutation builder as seen by the top level.
    typedef struct packed {
        logic busy;
        logic done;
    } t_build_status;

    // Byte n of a 32-bit key, n taken modulo 4.
    function automatic logic [BYTE_W-1:0] key_byte(input logic [KEY_W-1:0] word,
                                                   input logic [1:0] n);
        logic [BYTE_W-1:0] b;
        case (n)
            2'd0:    b = word[7:0];
            2'd1:    b = word[15:8];
            2'd2:    b = word[23:16];
            2'd3:    b = word[31:24];
            default: b = word[7:0];
        endcase
        return b;
    endfunction

endpackage

// ===== rtl/ksx_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ksx_table: permutation memory and key schedule sequencer
// Holds the 256 x 8 table in a synchronous memory. On a build request it fills
// the identity and runs the swap schedule, each swap step reading entries i
// and j, then writing both back; when idle the read port serves byte lookups.
// ----------------------------------------------------------------------------
module ksx_table (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_build_start,
    input  logic [ksx_pkg::KEY_W-1:0]    i_table_key,
    input  logic                         i_lk_en,
    input  logic [ksx_pkg::BYTE_W-1:0]   i_lk_addr,
    output ksx_pkg::t_build_status       o_status,
    output logic [ksx_pkg::BYTE_W-1:0]   o_lk_data
);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_FILL = 6'b000010,
        ST_RD_I = 6'b000100,
        ST_RD_J = 6'b001000,
        ST_WR_I = 6'b010000,
        ST_WR_J = 6'b100000
    } t_tbl_state;

    logic [ksx_pkg::BYTE_W-1:0] r_mem [256];
    logic [ksx_pkg::BYTE_W-1:0] r_rd_data;

    t_tbl_state                 r_state, n_state;
    logic [ksx_pkg::BYTE_W-1:0] r_idx, n_idx;
    logic [ksx_pkg::BYTE_W-1:0] r_j, n_j;
    logic [ksx_pkg::BYTE_W-1:0] r_si, n_si;
    logic                       r_done, n_done;

    logic                       rd_en;
    logic [ksx_pkg::BYTE_W-1:0] rd_addr;
    logic                       wr_en;
    logic [ksx_pkg::BYTE_W-1:0] wr_addr;
    logic [ksx_pkg::BYTE_W-1:0] wr_data;
    logic [ksx_pkg::BYTE_W-1:0] j_new;

    assign j_new = r_j + r_rd_data + ksx_pkg::key_byte(i_table_key, r_idx[1:0]);

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_j     = r_j;
        n_si    = r_si;
        n_done  = 1'b0;
        rd_en   = 1'b0;
        rd_addr = i_lk_addr;
        wr_en   = 1'b0;
        wr_addr = r_idx;
        wr_data = r_idx;
        case (r_state)
            ST_IDLE: begin
                rd_en = i_lk_en;
                if (i_build_start) begin
                    n_state = ST_FILL;
                    n_idx   = '0;
                end
            end
            ST_FILL: begin
                wr_en = 1'b1;
                if (r_idx == 8'hFF) begin
                    n_state = ST_RD_I;
                    n_idx   = '0;
                    n_j     = '0;
                end else begin
                    n_idx = r_idx + 8'd1;
                end
            end
            ST_RD_I: begin
                rd_en   = 1'b1;
                rd_addr = r_idx;
                n_state = ST_RD_J;
            end
            ST_RD_J: begin
                // The entry at i is now in the read register; pick j from it.
                rd_en   = 1'b1;
                rd_addr = j_new;
                n_si    = r_rd_data;
                n_j     = j_new;
                n_state = ST_WR_I;
            end
            ST_WR_I: begin
                wr_en   = 1'b1;
                wr_addr = r_idx;
                wr_data = r_rd_data;
                n_state = ST_WR_J;
            end
            ST_WR_J: begin
                // Written after the entry at i, so i equal to j leaves it intact.
                wr_en   = 1'b1;
                wr_addr = r_j;
                wr_data = r_si;
                if (r_idx == 8'hFF) begin
                    n_state = ST_IDLE;
                    n_done  = 1'b1;
                end else begin
                    n_idx   = r_idx + 8'd1;
                    n_state = ST_RD_I;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
        r_idx <= n_idx;
        r_j   <= n_j;
        r_si  <= n_si;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    assign o_status.busy = (r_state != ST_IDLE);
    assign o_status.done = r_done;
    assign o_lk_data     = r_rd_data;

endmodule

// ===== rtl/keyed_sbox_substitution_xor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_sbox_substitution_xor: keyed byte substitution with rolling XOR
// Top level: handshakes, configuration registers and the lookup pipeline.
// ----------------------------------------------------------------------------
// A request marked as start of payload, and the first request after reset,
// triggers a table rebuild before it is taken: an identity fill of all 256
// entries, then 256 swap steps, during which the input and configuration
// ports stall. Other requests are taken one per cycle while the output is
// not stalled, limited by the one table read per byte; each result passes
// the lookup register and the output register, and is held on the output
// until taken at an edge where i_out_stall is low. A new table_key applies
// at the next rebuild, a new xor_key to the next request.
// ----------------------------------------------------------------------------
module keyed_sbox_substitution_xor (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [ksx_pkg::BYTE_W-1:0]      i_data_byte,
    input  logic                            i_start_of_payload,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [ksx_pkg::BYTE_W-1:0]      o_cipher_byte,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [ksx_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [ksx_pkg::KEY_W-1:0]       i_cfg_data
);

    typedef enum logic [1:0] {
        ST_RUN   = 2'b01,
        ST_BUILD = 2'b10
    } t_top_state;

    t_top_state                 r_state;
    logic [ksx_pkg::KEY_W-1:0]  r_table_key;
    logic [ksx_pkg::KEY_W-1:0]  r_xor_key;
    logic                       r_built;
    logic                       r_skip_start;
    logic [1:0]                 r_phase;
    logic                       r_s1_vld;
    logic [ksx_pkg::BYTE_W-1:0] r_s1_key;
    logic                       r_out_vld;
    logic [ksx_pkg::BYTE_W-1:0] r_out_byte;

    ksx_pkg::t_build_status     build_status;
    logic [ksx_pkg::BYTE_W-1:0] lk_data;
    logic                       need_build;
    logic                       s1_adv;
    logic                       s1_free;
    logic                       in_acc;
    logic                       build_start;
    logic                       cfg_wr;

    // The request held after a rebuild is not a start any more.
    assign need_build  = !r_built || (i_start_of_payload && !r_skip_start);
    assign s1_adv      = r_s1_vld && (!r_out_vld || !i_out_stall);
    assign s1_free     = !r_s1_vld || s1_adv;
    assign in_acc      = i_in_valid && (r_state == ST_RUN) && !need_build && s1_free;
    assign build_start = i_in_valid && (r_state == ST_RUN) && need_build && !r_s1_vld;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    assign o_in_stall    = !((r_state == ST_RUN) && !need_build && s1_free);
    assign o_cfg_ready   = (r_state == ST_RUN);
    assign o_out_valid   = r_out_vld;
    assign o_cipher_byte = r_out_byte;

    ksx_table u_table (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_build_start (build_start),
        .i_table_key   (r_table_key),
        .i_lk_en       (in_acc),
        .i_lk_addr     (i_data_byte),
        .o_status      (build_status),
        .o_lk_data     (lk_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_RUN;
            r_table_key  <= ksx_pkg::TABLE_KEY_RESET;
            r_xor_key    <= ksx_pkg::XOR_KEY_RESET;
            r_built      <= 1'b0;
            r_skip_start <= 1'b0;
            r_phase      <= 2'd0;
            r_s1_vld     <= 1'b0;
            r_out_vld    <= 1'b0;
        end else begin
            if (cfg_wr) begin
                case (i_cfg_index)
                    ksx_pkg::REG_TABLE_KEY: r_table_key <= i_cfg_data;
                    ksx_pkg::REG_XOR_KEY:   r_xor_key   <= i_cfg_data;
                    default: ;
                endcase
            end

            case (r_state)
                ST_RUN: begin
                    if (build_start) begin
                        r_state <= ST_BUILD;
                    end
                end
                ST_BUILD: begin
                    if (build_status.done) begin
                        r_state      <= ST_RUN;
                        r_built      <= 1'b1;
                        r_skip_start <= 1'b1;
                        r_phase      <= 2'd0;
                    end
                end
                default: begin
                    r_state <= ST_RUN;
                end
            endcase

            if (in_acc) begin
                r_skip_start <= 1'b0;
                r_phase      <= r_phase + 2'd1;
                r_s1_vld     <= 1'b1;
            end else if (s1_adv) begin
                r_s1_vld <= 1'b0;
            end

            if (s1_adv) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end

        if (in_acc) begin
            r_s1_key <= ksx_pkg::key_byte(r_xor_key, r_phase);
        end
        if (s1_adv) begin
            r_out_byte <= lk_data ^ r_s1_key;
        end
    end

endmodule
